>>> sv/afk_pkg.sv
package afk_pkg;

  localparam int QB = 30;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;

  // sine/cosine unit depth in register stages
  localparam int TRIG_LAT = 12;

  // Horner divisors split into a shift and an odd factor
  localparam int SIN_K [4] = '{3, 1, 2, 1};
  localparam int SIN_D [4] = '{9, 21, 5, 3};
  localparam int COS_K [4] = '{1, 3, 1, 2};
  localparam int COS_D [4] = '{45, 7, 15, 3};

  localparam int OUT_W = 19;

  typedef enum logic [1:0] {
    REG_LINK_ONE   = 2'd0,
    REG_LINK_TWO   = 2'd1,
    REG_LINK_THREE = 2'd2
  } cfg_reg_t;

  // Q30 product back to Q30, half up
  function automatic logic [30:0] rnd30(input logic [61:0] p);
    logic [61:0] s;
    s = p + 62'(32'h2000_0000);
    return 31'(s >> QB);
  endfunction

endpackage

>>> sv/afk_trig.sv
module afk_trig #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic [ANGLE_BITS-1:0]          ang,
  output logic signed [TRIG_FRAC_BITS+1:0] sn,
  output logic signed [TRIG_FRAC_BITS+1:0] cs
);
  import afk_pkg::*;

  localparam int RB = ANGLE_BITS - 3;
  localparam int TF = TRIG_FRAC_BITS;

  // octant fold
  logic [2:0]    oct;
  logic [RB-1:0] r0;
  logic [RB:0]   r;
  logic [RB+32:0] xprod1;
  logic [2:0]    oct1, oct2, oct3;
  logic [RB+33:0] xr;
  logic [30:0]   x_s2, x_s3;
  logic [61:0]   x2p;
  logic [30:0]   x2c;

  logic [30:0]   xd   [0:6];
  logic [30:0]   x2d  [0:6];
  logic [2:0]    octd [0:7];

  logic [30:0]   ms_in [0:3];
  logic [30:0]   mc_in [0:3];
  logic [62:0]   qs    [0:3];
  logic [62:0]   qc    [0:3];
  logic [30:0]   ts    [0:3];
  logic [30:0]   tc    [0:3];
  logic [61:0]   ps    [0:2];
  logic [61:0]   pc    [0:2];
  logic [61:0]   fps, fpc;

  logic [30:0]   s_v, c_v, sp, cp;
  logic [TF:0]   msp, mcp;
  logic [30:0]   ssum, csum;

  always_comb begin
    oct = ang[ANGLE_BITS-1 -: 3];
    r0  = ang[RB-1:0];
    if (oct[0]) begin
      r = ((RB+1)'(1) << RB) - {1'b0, r0};
    end else begin
      r = {1'b0, r0};
    end
  end

  always_ff @(posedge clk) begin
    xprod1 <= (RB+33)'(r) * (RB+33)'(PI_Q30);
    oct1   <= oct;
  end

  assign xr = {1'b0, xprod1} + ((RB+34)'(1) << (ANGLE_BITS-2));

  always_ff @(posedge clk) begin
    x_s2 <= 31'(xr >> (ANGLE_BITS-1));
    oct2 <= oct1;
    x2p  <= 62'(x_s2) * 62'(x_s2);
    x_s3 <= x_s2;
    oct3 <= oct2;
  end

  assign x2c = rnd30(x2p);

  always_ff @(posedge clk) begin
    x2d[0]  <= x2c;
    xd[0]   <= x_s3;
    octd[0] <= oct3;
    for (int j = 1; j < 7; j++) begin
      x2d[j] <= x2d[j-1];
      xd[j]  <= xd[j-1];
    end
    for (int j = 1; j < 8; j++) begin
      octd[j] <= octd[j-1];
    end
  end

  // Horner steps: exact divide by odd constant via reciprocal multiply
  for (genvar i = 0; i < 4; i++) begin : g_step
    localparam int SS = 31 + $clog2(SIN_D[i]);
    localparam int SC = 31 + $clog2(COS_D[i]);
    localparam logic [31:0] MS =
      32'(((64'd1 << SS) + 64'(SIN_D[i]) - 64'd1) / 64'(SIN_D[i]));
    localparam logic [31:0] MC =
      32'(((64'd1 << SC) + 64'(COS_D[i]) - 64'd1) / 64'(COS_D[i]));

    if (i == 0) begin : g_first
      assign ms_in[i] = x2c >> SIN_K[i];
      assign mc_in[i] = x2c >> COS_K[i];
    end else begin : g_next
      assign ms_in[i] = rnd30(ps[i-1]) >> SIN_K[i];
      assign mc_in[i] = rnd30(pc[i-1]) >> COS_K[i];
    end

    always_ff @(posedge clk) begin
      qs[i] <= 63'(ms_in[i]) * 63'(MS);
      qc[i] <= 63'(mc_in[i]) * 63'(MC);
    end

    assign ts[i] = Q30_ONE - 31'(qs[i] >> SS);
    assign tc[i] = Q30_ONE - 31'(qc[i] >> SC);

    if (i < 3) begin : g_mul
      always_ff @(posedge clk) begin
        ps[i] <= 62'(x2d[2*i]) * 62'(ts[i]);
        pc[i] <= 62'(x2d[2*i]) * 62'(tc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    fps <= 62'(xd[6]) * 62'(ts[3]);
    fpc <= 62'(x2d[6]) * 62'(tc[3]);
  end

  always_comb begin
    s_v = rnd30(fps);
    c_v = Q30_ONE - (rnd30(fpc) >> 1);
    if (octd[7][0]) begin
      sp = c_v;
      cp = s_v;
    end else begin
      sp = s_v;
      cp = c_v;
    end
    ssum = sp + (31'(1) << (29 - TF));
    csum = cp + (31'(1) << (29 - TF));
    msp  = (TF+1)'(ssum >> (30 - TF));
    mcp  = (TF+1)'(csum >> (30 - TF));
  end

  always_ff @(posedge clk) begin
    case (octd[7][2:1])
      2'd0: begin
        sn <= $signed({1'b0, msp});
        cs <= $signed({1'b0, mcp});
      end
      2'd1: begin
        sn <= $signed({1'b0, mcp});
        cs <= -$signed({1'b0, msp});
      end
      2'd2: begin
        sn <= -$signed({1'b0, msp});
        cs <= -$signed({1'b0, mcp});
      end
      default: begin
        sn <= -$signed({1'b0, mcp});
        cs <= $signed({1'b0, msp});
      end
    endcase
  end

endmodule

>>> sv/arm_forward_kinematics_3dof_unit.sv
// Pipeline: the input angle register, the sine/cosine units, then the length multiply,
//   sum, rounding, reach multiply and output saturation registers.
// Throughput: one joint triple per cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall: done pulses for one cycle with pos_x/pos_y/pos_z.
// Reset (rst, synchronous) clears the valid pipeline and the link lengths to 0.
module arm_forward_kinematics_3dof_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ANGLE_BITS-1:0]         base_angle,
  input  logic [ANGLE_BITS-1:0]         shoulder_angle,
  input  logic [ANGLE_BITS-1:0]         elbow_angle,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [LENGTH_BITS-1:0]        cfg_data,
  output logic                          done,
  output logic signed [afk_pkg::OUT_W-1:0] pos_x,
  output logic signed [afk_pkg::OUT_W-1:0] pos_y,
  output logic signed [afk_pkg::OUT_W-1:0] pos_z
);
  import afk_pkg::*;

  localparam int LB   = LENGTH_BITS;
  localparam int TF   = TRIG_FRAC_BITS;
  localparam int TW   = TF + 2;
  localparam int PW1  = LB + 1 + TW;
  localparam int SUMW = LB + TF + 4;
  localparam int RW   = LB + 3;
  localparam int PXW  = TW + RW;
  localparam int EW   = RW + OUT_W + 1;
  localparam int LAT  = TRIG_LAT + 6;
  localparam logic signed [EW-1:0] SAT_MAX = EW'(262143);
  localparam logic signed [EW-1:0] SAT_MIN = -EW'(262144);

  logic [LB-1:0] link_one, link_two, link_three;
  logic [LAT-1:0] vld;
  logic accept;

  logic [ANGLE_BITS-1:0] t1, t2, t23;
  logic signed [TW-1:0] s1, c1, s2, c2, s23, c23;
  logic signed [TW-1:0] s1d [0:2];
  logic signed [TW-1:0] c1d [0:2];

  logic signed [PW1-1:0] pc2, pc23, ps2, ps23;
  logic signed [SUMW-1:0] base, sum_r, sum_z;
  logic signed [RW-1:0] reach, z1, z2;
  logic signed [PXW-1:0] px, py;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign done      = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      link_one   <= '0;
      link_two   <= '0;
      link_three <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINK_ONE:   link_one   <= cfg_data;
        REG_LINK_TWO:   link_two   <= cfg_data;
        REG_LINK_THREE: link_three <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    t1  <= base_angle;
    t2  <= shoulder_angle;
    t23 <= shoulder_angle + elbow_angle;
  end

  afk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TF)) u_trig1 (
    .clk(clk), .ang(t1), .sn(s1), .cs(c1));
  afk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TF)) u_trig2 (
    .clk(clk), .ang(t2), .sn(s2), .cs(c2));
  afk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TF)) u_trig23 (
    .clk(clk), .ang(t23), .sn(s23), .cs(c23));

  // v / 2^TF, half away from zero
  function automatic logic signed [RW-1:0] rnd_sum(input logic signed [SUMW-1:0] v);
    logic [SUMW-1:0] m;
    m = v[SUMW-1] ? SUMW'(-v) : SUMW'(v);
    m = (m + (SUMW'(1) << (TF-1))) >> TF;
    return v[SUMW-1] ? -$signed(RW'(m)) : $signed(RW'(m));
  endfunction

  function automatic logic signed [RW-1:0] rnd_prod(input logic signed [PXW-1:0] v);
    logic [PXW-1:0] m;
    m = v[PXW-1] ? PXW'(-v) : PXW'(v);
    m = (m + (PXW'(1) << (TF-1))) >> TF;
    return v[PXW-1] ? -$signed(RW'(m)) : $signed(RW'(m));
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > SAT_MAX) begin
      e = SAT_MAX;
    end else if (e < SAT_MIN) begin
      e = SAT_MIN;
    end
    return OUT_W'(e);
  endfunction

  assign base = $signed({4'b0000, link_one, {TF{1'b0}}});

  always_ff @(posedge clk) begin
    pc2  <= $signed({1'b0, link_two}) * c2;
    pc23 <= $signed({1'b0, link_three}) * c23;
    ps2  <= $signed({1'b0, link_two}) * s2;
    ps23 <= $signed({1'b0, link_three}) * s23;
    s1d[0] <= s1;
    c1d[0] <= c1;
    s1d[1] <= s1d[0];
    c1d[1] <= c1d[0];
    s1d[2] <= s1d[1];
    c1d[2] <= c1d[1];

    sum_r <= base + SUMW'(pc2) + SUMW'(pc23);
    sum_z <= base + SUMW'(ps2) + SUMW'(ps23);

    reach <= rnd_sum(sum_r);
    z1    <= rnd_sum(sum_z);

    px <= PXW'(c1d[2]) * PXW'(reach);
    py <= PXW'(s1d[2]) * PXW'(reach);
    z2 <= z1;

    pos_x <= sat(rnd_prod(px));
    pos_y <= sat(rnd_prod(py));
    pos_z <= sat(z2);
  end

endmodule

>>> sv/afk_check.sv
module afk_check #(
  parameter int LAT = 18
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic signed [18:0]       pos_x,
  input logic signed [18:0]       pos_y,
  input logic signed [18:0]       pos_z
);

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a transfer in");

  a_xy_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pos_x != 19'h40000) && (pos_y != 19'h40000))
    else $error("x/y outside reach");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pos_z >= -19'sd131070))
    else $error("z below reach");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind arm_forward_kinematics_3dof_unit afk_check #(.LAT(18)) u_afk_check (.*);

>>> tb/sv/arm_forward_kinematics_3dof_unit_tb.sv
module arm_forward_kinematics_3dof_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afk_pkg::*;

  localparam int LATENCY = 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
  } joints_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } position_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [15:0] base_angle, shoulder_angle, elbow_angle;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic done;
  logic signed [OUT_W-1:0] pos_x, pos_y, pos_z;

  joints_t joint_queue[$];
  position_t position_queue[$];
  logic [15:0] link_len[3];
  int errors = 0;
  int moves_sent = 0;
  int positions_seen = 0;
  int cfg_writes = 0;
  int cycles = 0;
  int gap = 0;
  bit quiet = 0;

  arm_forward_kinematics_3dof_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .base_angle(base_angle), .shoulder_angle(shoulder_angle), .elbow_angle(elbow_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'h2000_0000) >> 30;
  endfunction

  function automatic longint q15_of(longint unsigned v, bit neg);
    longint m;
    m = longint'((v + 64'd16384) >> 15);
    return neg ? -m : m;
  endfunction

  // Taylor sin/cos on the folded octant residue, then quadrant fixup
  function automatic void sin_cos(input logic [15:0] ang, output longint sn,
                                  output longint cs);
    longint unsigned r, x, x2, t, s, c, sp, cp;
    logic [2:0] oct;
    oct = ang[15:13];
    r = ang[12:0];
    if (oct[0]) r = 64'd8192 - r;
    x = (r * 64'(PI_Q30) + 64'd16384) >> 15;
    x2 = q30_mul(x, x);
    t = 64'h4000_0000 - x2 / 72;
    t = 64'h4000_0000 - q30_mul(x2, t) / 42;
    t = 64'h4000_0000 - q30_mul(x2, t) / 20;
    t = 64'h4000_0000 - q30_mul(x2, t) / 6;
    s = q30_mul(x, t);
    t = 64'h4000_0000 - x2 / 90;
    t = 64'h4000_0000 - q30_mul(x2, t) / 56;
    t = 64'h4000_0000 - q30_mul(x2, t) / 30;
    t = 64'h4000_0000 - q30_mul(x2, t) / 12;
    c = 64'h4000_0000 - q30_mul(x2, t) / 2;
    if (oct[0]) begin
      sp = c; cp = s;
    end else begin
      sp = s; cp = c;
    end
    case (oct[2:1])
      2'd0: begin sn = q15_of(sp, 0); cs = q15_of(cp, 0); end
      2'd1: begin sn = q15_of(cp, 0); cs = q15_of(sp, 1); end
      2'd2: begin sn = q15_of(sp, 1); cs = q15_of(cp, 1); end
      default: begin sn = q15_of(cp, 1); cs = q15_of(sp, 0); end
    endcase
  endfunction

  function automatic longint unscale_q15(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 16384) >>> 15;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp19(longint v);
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v[OUT_W-1:0];
  endfunction

  function automatic position_t arm_position(joints_t j);
    longint s1, c1, s2, c2, s23, c23, base, reach, height;
    position_t p;
    sin_cos(j.t1, s1, c1);
    sin_cos(j.t2, s2, c2);
    sin_cos(j.t2 + j.t3, s23, c23);
    base = longint'(link_len[0]) * 32768;
    reach = unscale_q15(base + longint'(link_len[1]) * c2 + longint'(link_len[2]) * c23);
    height = unscale_q15(base + longint'(link_len[1]) * s2 + longint'(link_len[2]) * s23);
    p.x = clamp19(unscale_q15(c1 * reach));
    p.y = clamp19(unscale_q15(s1 * reach));
    p.z = clamp19(height);
    return p;
  endfunction

  // driver: one start per queued joint triple, random idle bursts
  always @(posedge clk) begin
    joints_t j;
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = 1'b0;
      if (start && !busy) begin
        position_queue.push_back(arm_position('{base_angle, shoulder_angle, elbow_angle}));
        moves_sent++;
      end
      if (start && busy) begin
        next_start = 1'b1;
      end else if (gap > 0) begin
        gap--;
      end else if (joint_queue.size() > 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          gap = $urandom_range(1, 17);
        end else begin
          j = joint_queue.pop_front();
          base_angle <= j.t1;
          shoulder_angle <= j.t2;
          elbow_angle <= j.t3;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // monitor: done pulses cannot be held off
  always @(posedge clk) begin
    position_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index != REG_UNMAPPED) link_len[cfg_index] <= cfg_data;
      end
      if (done) begin
        positions_seen++;
        if (position_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, pos_x, pos_y, pos_z);
        end else begin
          e = position_queue.pop_front();
          if (pos_x !== e.x) begin
            errors++;
            $display("%0t: pos_x expected %0d actual %0d", $time, e.x, pos_x);
          end
          if (pos_y !== e.y) begin
            errors++;
            $display("%0t: pos_y expected %0d actual %0d", $time, e.y, pos_y);
          end
          if (pos_z !== e.z) begin
            errors++;
            $display("%0t: pos_z expected %0d actual %0d", $time, e.z, pos_z);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (joint_queue.size() > 0 || start || position_queue.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_links(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
    wait_idle();
    write_reg(REG_LINK_ONE, a1);
    write_reg(REG_LINK_TWO, a2);
    write_reg(REG_LINK_THREE, a3);
    // unmapped index must not disturb the links
    write_reg(REG_UNMAPPED, 16'($urandom));
  endtask

  function automatic logic [15:0] pick_angle();
    // octant edges are where the folding logic can slip
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 4) - 2);
    return 16'($urandom);
  endfunction

  task automatic queue_random(int n);
    repeat (n) joint_queue.push_back('{pick_angle(), pick_angle(), pick_angle()});
  endtask

  initial begin
    link_len = '{16'd0, 16'd0, 16'd0};
    rst <= 1'b1;
    start <= 1'b0;
    base_angle <= '0;
    shoulder_angle <= '0;
    elbow_angle <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_LINK_ONE;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset lengths are zero: everything lands on the origin
    joint_queue.push_back('{16'h1234, 16'h4000, 16'hFFFF});
    joint_queue.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});

    set_links(16'd1000, 16'd2000, 16'd3000);
    for (int k = 0; k < 8; k++)
      joint_queue.push_back('{16'(k * 16'h2000), 16'(k * 16'h2000), 16'h0000});
    joint_queue.push_back('{16'h1FFF, 16'h2001, 16'h5FFF});
    joint_queue.push_back('{16'h0000, 16'hC000, 16'h8000});
    joint_queue.push_back('{16'hFFFF, 16'hFFFF, 16'h0001});   // elbow sum wraps
    joint_queue.push_back('{16'h5555, 16'hAAAA, 16'hAAAA});

    set_links(16'hFFFF, 16'hFFFF, 16'hFFFF);
    joint_queue.push_back('{16'h0000, 16'h4000, 16'h0000});   // full height
    joint_queue.push_back('{16'h0000, 16'h0000, 16'h0000});   // full reach
    joint_queue.push_back('{16'h8000, 16'hC000, 16'h0000});   // lowest z
    joint_queue.push_back('{16'h6000, 16'h8000, 16'h8000});
    joint_queue.push_back('{16'hA000, 16'hE000, 16'hFFFF});
    queue_random(100);

    set_links(16'd0, 16'hFFFF, 16'd0);
    queue_random(80);
    set_links(16'd1, 16'd0, 16'hFFFF);
    queue_random(80);
    set_links(16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(120);
    set_links(16'hFFFF, 16'd1, 16'h8000);
    queue_random(100);

    set_links(16'($urandom), 16'($urandom), 16'($urandom));
    quiet = 1;
    queue_random(100);

    wait_idle();
    $display("%0d joint triples sent, %0d positions checked, %0d register writes,",
             moves_sent, positions_seen, cfg_writes);
    $display("link lengths from zero to full scale, angles across all octants");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
